// ===== rtl/dsbm_pkg.sv =====
// ----------------------------------------------------------------------------
// dsbm_pkg
// shared types and constants for the domain suffix blocklist matcher
// ----------------------------------------------------------------------------
`default_nettype none

package dsbm_pkg;

	localparam logic [7:0] DOT_CHAR = 8'h2E;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] ch;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic       verdict;
		logic [1:0] status;
	} result_t;

	// write enables from the sequencer to the stores
	typedef struct packed {
		logic nbuf_we;
		logic emem_we;
		logic len_we;
	} mem_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN_RD,
		ST_LEN_CHK,
		ST_CMP_RD,
		ST_CMP_CHK,
		ST_DOT_RD,
		ST_DOT_CHK,
		ST_CP_RD,
		ST_CP_WR,
		ST_RESULT
	} ctrl_state_t;

endpackage

`default_nettype wire

// ===== rtl/dsbm_store.sv =====
// ----------------------------------------------------------------------------
// dsbm_store
// name buffer, entry character store and entry length store
// ----------------------------------------------------------------------------
`default_nettype none

module dsbm_store #(
	parameter int MAX_ENTRIES  = 64,
	parameter int MAX_NAME_LEN = 256
) (
	input  wire                                    clk,
	input  dsbm_pkg::mem_ctl_t                     ctl,
	input  wire [$clog2(MAX_NAME_LEN)-1:0]         nbuf_waddr,
	input  wire [7:0]                              nbuf_wdata,
	input  wire [$clog2(MAX_NAME_LEN)-1:0]         nbuf_raddr,
	output logic [7:0]                             nbuf_rdata,
	input  wire [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)
		+ $clog2(MAX_NAME_LEN)-1:0]                emem_waddr,
	input  wire [7:0]                              emem_wdata,
	input  wire [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)
		+ $clog2(MAX_NAME_LEN)-1:0]                emem_raddr,
	output logic [7:0]                             emem_rdata,
	input  wire [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] len_waddr,
	input  wire [$clog2(MAX_NAME_LEN+1)-1:0]       len_wdata,
	input  wire [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] len_raddr,
	output logic [$clog2(MAX_NAME_LEN+1)-1:0]      len_rdata
);
	import dsbm_pkg::*;

	localparam int KW  = $clog2(MAX_NAME_LEN);
	localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NLW = $clog2(MAX_NAME_LEN + 1);

	logic [7:0]     nbuf_mem [MAX_NAME_LEN];
	logic [7:0]     emem_mem [(2**EW) * (2**KW)];
	logic [NLW-1:0] len_mem  [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (ctl.nbuf_we) begin
			nbuf_mem[nbuf_waddr] <= nbuf_wdata;
		end
		nbuf_rdata <= nbuf_mem[nbuf_raddr];
	end

	// entry row is entry index over character index
	always_ff @(posedge clk) begin
		if (ctl.emem_we) begin
			emem_mem[emem_waddr] <= emem_wdata;
		end
		emem_rdata <= emem_mem[emem_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		len_rdata <= len_mem[len_raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/dsbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsbm_ctrl
// sequencer: collects characters, copies entries, walks entries with one compare
// ----------------------------------------------------------------------------
`default_nettype none

module dsbm_ctrl #(
	parameter int MAX_ENTRIES  = 64,
	parameter int MAX_NAME_LEN = 256
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    item_valid,
	output logic                                   item_stall,
	input  dsbm_pkg::item_t                        item,
	output logic                                   done,
	input  wire                                    res_take,
	output dsbm_pkg::result_t                      res,
	output dsbm_pkg::mem_ctl_t                     ctl,
	output logic [$clog2(MAX_NAME_LEN)-1:0]        nbuf_waddr,
	output logic [7:0]                             nbuf_wdata,
	output logic [$clog2(MAX_NAME_LEN)-1:0]        nbuf_raddr,
	input  wire [7:0]                              nbuf_rdata,
	output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)
		+ $clog2(MAX_NAME_LEN)-1:0]                emem_waddr,
	output logic [7:0]                             emem_wdata,
	output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)
		+ $clog2(MAX_NAME_LEN)-1:0]                emem_raddr,
	input  wire [7:0]                              emem_rdata,
	output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] len_waddr,
	output logic [$clog2(MAX_NAME_LEN+1)-1:0]      len_wdata,
	output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] len_raddr,
	input  wire [$clog2(MAX_NAME_LEN+1)-1:0]       len_rdata
);
	import dsbm_pkg::*;

	localparam int KW  = $clog2(MAX_NAME_LEN);
	localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NLW = $clog2(MAX_NAME_LEN + 1);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);

	ctrl_state_t    state_q, state_n;
	logic [NLW-1:0] nlen_q, nlen_n;
	logic           ovf_q, ovf_n;
	logic [CW-1:0]  cnt_q, cnt_n;
	logic [EW-1:0]  e_q, e_n;
	logic [KW-1:0]  k_q, k_n;
	logic [NLW-1:0] elen_q, elen_n;
	logic [KW-1:0]  base_q, base_n;
	result_t        res_q, res_n;

	logic           buf_full;
	logic           last_entry;
	logic           last_cmp;
	logic           last_copy;
	logic [NLW-1:0] nlen_inc;

	assign buf_full   = (nlen_q == NLW'(MAX_NAME_LEN));
	assign nlen_inc   = nlen_q + NLW'(1);
	assign last_entry = ((CW'(e_q) + CW'(1)) == cnt_q);
	assign last_cmp   = ((NLW'(k_q) + NLW'(1)) == elen_q);
	assign last_copy  = ((NLW'(k_q) + NLW'(1)) == nlen_q);
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nlen_q  <= '0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			nlen_q  <= nlen_n;
			ovf_q   <= ovf_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		e_q    <= e_n;
		k_q    <= k_n;
		elen_q <= elen_n;
		base_q <= base_n;
		res_q  <= res_n;
	end

	always_comb begin
		state_n    = state_q;
		nlen_n     = nlen_q;
		ovf_n      = ovf_q;
		cnt_n      = cnt_q;
		e_n        = e_q;
		k_n        = k_q;
		elen_n     = elen_q;
		base_n     = base_q;
		res_n      = res_q;
		item_stall = 1'b1;
		done       = 1'b0;
		ctl        = '0;
		nbuf_waddr = nlen_q[KW-1:0];
		nbuf_wdata = item.ch;
		nbuf_raddr = k_q;
		emem_waddr = {cnt_q[EW-1:0], k_q};
		emem_wdata = nbuf_rdata;
		emem_raddr = {e_q, k_q};
		len_waddr  = cnt_q[EW-1:0];
		len_wdata  = nlen_q;
		len_raddr  = e_q;

		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (buf_full) begin
						ovf_n = 1'b1;
					end else begin
						ctl.nbuf_we = 1'b1;
						nlen_n      = nlen_inc;
					end
					if (item.last_char) begin
						res_n = '{verdict: 1'b0, status: STATUS_OK};
						e_n   = '0;
						k_n   = '0;
						if (ovf_q || buf_full) begin
							res_n.status = STATUS_TOO_LONG;
							state_n      = ST_RESULT;
						end else if (item.req_type == REQ_QUERY) begin
							state_n = (cnt_q == '0) ? ST_RESULT : ST_LEN_RD;
						end else if (cnt_q == CW'(MAX_ENTRIES)) begin
							res_n.status = STATUS_FULL;
							state_n      = ST_RESULT;
						end else begin
							state_n = ST_CP_RD;
						end
					end
				end
			end
			ST_LEN_RD: begin
				state_n = ST_LEN_CHK;
			end
			ST_LEN_CHK: begin
				elen_n = len_rdata;
				base_n = KW'(nlen_q - len_rdata);
				k_n    = '0;
				if (len_rdata == '0 || len_rdata > nlen_q) begin
					// entry cannot fit, move on
					if (last_entry) begin
						state_n = ST_RESULT;
					end else begin
						e_n     = e_q + EW'(1);
						state_n = ST_LEN_RD;
					end
				end else begin
					state_n = ST_CMP_RD;
				end
			end
			ST_CMP_RD: begin
				nbuf_raddr = base_q + k_q;
				state_n    = ST_CMP_CHK;
			end
			ST_CMP_CHK: begin
				if (nbuf_rdata != emem_rdata) begin
					if (last_entry) begin
						state_n = ST_RESULT;
					end else begin
						e_n     = e_q + EW'(1);
						state_n = ST_LEN_RD;
					end
				end else if (last_cmp) begin
					if (base_q == '0) begin
						res_n.verdict = 1'b1;
						state_n       = ST_RESULT;
					end else begin
						state_n = ST_DOT_RD;
					end
				end else begin
					k_n     = k_q + KW'(1);
					state_n = ST_CMP_RD;
				end
			end
			ST_DOT_RD: begin
				nbuf_raddr = base_q - KW'(1);
				state_n    = ST_DOT_CHK;
			end
			ST_DOT_CHK: begin
				if (nbuf_rdata == DOT_CHAR) begin
					res_n.verdict = 1'b1;
					state_n       = ST_RESULT;
				end else if (last_entry) begin
					state_n = ST_RESULT;
				end else begin
					e_n     = e_q + EW'(1);
					state_n = ST_LEN_RD;
				end
			end
			ST_CP_RD: begin
				nbuf_raddr = k_q;
				state_n    = ST_CP_WR;
			end
			ST_CP_WR: begin
				ctl.emem_we = 1'b1;
				if (last_copy) begin
					ctl.len_we = 1'b1;
					cnt_n      = cnt_q + CW'(1);
					state_n    = ST_RESULT;
				end else begin
					k_n     = k_q + KW'(1);
					state_n = ST_CP_RD;
				end
			end
			ST_RESULT: begin
				done = 1'b1;
				if (res_take) begin
					nlen_n  = '0;
					ovf_n   = 1'b0;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/domain_suffix_blocklist_match_core.sv =====
// ----------------------------------------------------------------------------
// domain_suffix_blocklist_match_core
// streams domain names a character at a time; adds blocked entries and answers
// queries with an exact or dot-bounded suffix match against every entry
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// item      in         item_valid / item_stall      item   (req_type, ch, last_char)
// result    out        result_valid / result_stall  result (verdict, status)
//
// a character that is not the last of its name goes into the name buffer; the sequencer stays idle
// end of an add: accept, then per character a buffer read and an entry write (copy), then result
// end of a query: accept, then per entry a length read and check, a read and compare per
//   character up to a mismatch and a dot check, through one buffer port, then result
// reset clears the entry count and the name state; stores are not cleared
// a pending result is held in the output register while the next name streams in
// ----------------------------------------------------------------------------
`default_nettype none

module domain_suffix_blocklist_match_core #(
	parameter int MAX_ENTRIES  = 64,
	parameter int MAX_NAME_LEN = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_stall,
	input  dsbm_pkg::item_t    item,
	output logic               result_valid,
	input  wire                result_stall,
	output dsbm_pkg::result_t  result
);
	import dsbm_pkg::*;

	localparam int KW  = $clog2(MAX_NAME_LEN);
	localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NLW = $clog2(MAX_NAME_LEN + 1);

	// memory port wiring between sequencer and stores
	mem_ctl_t          ctl;
	logic [KW-1:0]     nbuf_waddr, nbuf_raddr;
	logic [7:0]        nbuf_wdata, nbuf_rdata;
	logic [EW+KW-1:0]  emem_waddr, emem_raddr;
	logic [7:0]        emem_wdata, emem_rdata;
	logic [EW-1:0]     len_waddr, len_raddr;
	logic [NLW-1:0]    len_wdata, len_rdata;

	// result hand-off from the sequencer
	logic              done;
	logic              res_take;
	result_t           res;

	// output register
	logic              result_valid_q;
	result_t           result_q;

	// the sequencer may hand over when the output slot is free or draining
	assign res_take     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (done && res_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && res_take) begin
			result_q <= res;
		end
	end

	dsbm_ctrl #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.MAX_NAME_LEN (MAX_NAME_LEN)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.done       (done),
		.res_take   (res_take),
		.res        (res),
		.ctl        (ctl),
		.nbuf_waddr (nbuf_waddr),
		.nbuf_wdata (nbuf_wdata),
		.nbuf_raddr (nbuf_raddr),
		.nbuf_rdata (nbuf_rdata),
		.emem_waddr (emem_waddr),
		.emem_wdata (emem_wdata),
		.emem_raddr (emem_raddr),
		.emem_rdata (emem_rdata),
		.len_waddr  (len_waddr),
		.len_wdata  (len_wdata),
		.len_raddr  (len_raddr),
		.len_rdata  (len_rdata)
	);

	dsbm_store #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.MAX_NAME_LEN (MAX_NAME_LEN)
	) u_store (
		.clk        (clk),
		.ctl        (ctl),
		.nbuf_waddr (nbuf_waddr),
		.nbuf_wdata (nbuf_wdata),
		.nbuf_raddr (nbuf_raddr),
		.nbuf_rdata (nbuf_rdata),
		.emem_waddr (emem_waddr),
		.emem_wdata (emem_wdata),
		.emem_raddr (emem_raddr),
		.emem_rdata (emem_rdata),
		.len_waddr  (len_waddr),
		.len_wdata  (len_wdata),
		.len_raddr  (len_raddr),
		.len_rdata  (len_rdata)
	);

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the domain suffix blocklist matcher: streams added entries and
// queries with random gaps and stalls, predicts each verdict and status, and
// compares every result in order
// ----------------------------------------------------------------------------
`default_nettype none

class blocklist_scoreboard;
	// predictor copy of the entry table and the name being received
	byte unsigned entry_text[64][256];
	int entry_len[64];
	int entry_total;
	byte unsigned name_text[256];
	int name_len;
	bit name_long;
	dsbm_pkg::result_t verdict_queue[$];
	int errors;
	int results_seen;
	int blocked_seen;
	int full_seen;
	int long_seen;

	function void clear();
		entry_total = 0;
		name_len = 0;
		name_long = 0;
		verdict_queue.delete();
		errors = 0;
	endfunction

	function bit suffix_hit(int e);
		int base;
		int k;
		if (entry_len[e] == 0 || entry_len[e] > name_len) return 0;
		base = name_len - entry_len[e];
		for (k = 0; k < entry_len[e]; k++)
			if (name_text[base + k] != entry_text[e][k]) return 0;
		return base == 0 || name_text[base - 1] == dsbm_pkg::DOT_CHAR;
	endfunction

	function void note_request(dsbm_pkg::item_t it);
		dsbm_pkg::result_t r;
		int e;
		if (name_len < 256) begin
			name_text[name_len] = it.ch;
			name_len++;
		end else begin
			name_long = 1;
		end
		if (!it.last_char) return;
		r.verdict = 0;
		r.status = dsbm_pkg::STATUS_OK;
		if (name_long) begin
			r.status = dsbm_pkg::STATUS_TOO_LONG;
		end else if (it.req_type == dsbm_pkg::REQ_QUERY) begin
			for (e = 0; e < entry_total; e++)
				if (suffix_hit(e)) r.verdict = 1;
		end else if (entry_total >= 64) begin
			r.status = dsbm_pkg::STATUS_FULL;
		end else begin
			for (e = 0; e < name_len; e++) entry_text[entry_total][e] = name_text[e];
			entry_len[entry_total] = name_len;
			entry_total++;
		end
		verdict_queue = {verdict_queue, r};
		name_len = 0;
		name_long = 0;
	endfunction

	function void check_result(dsbm_pkg::result_t got);
		dsbm_pkg::result_t want;
		results_seen++;
		if (verdict_queue.size() == 0) begin
			$error("unexpected result verdict=%0d status=%0d", got.verdict, got.status);
			errors++;
			return;
		end
		want = verdict_queue.pop_front();
		if (got.verdict !== want.verdict) begin
			$error("verdict expected %0d actual %0d", want.verdict, got.verdict);
			errors++;
		end
		if (got.status !== want.status) begin
			$error("status expected %0d actual %0d", want.status, got.status);
			errors++;
		end
		if (want.verdict) blocked_seen++;
		if (want.status == dsbm_pkg::STATUS_FULL) full_seen++;
		if (want.status == dsbm_pkg::STATUS_TOO_LONG) long_seen++;
	endfunction
endclass

module tb_top;
	import dsbm_pkg::*;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;

	blocklist_scoreboard board;
	int requests_sent;
	bit hold_results;

	// pool of labels used both in entries and in queries, so that hits happen
	string label_pool[8] = '{"ads", "evil", "com", "net", "x", "track", "a.b", "cdn"};

	domain_suffix_blocklist_match_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// send one character; waits for acceptance, then notes it for prediction
	task automatic send_char(logic kind, logic [7:0] c, logic last, bit gaps);
		int idle_cycles;
		idle_cycles = gaps ? $urandom_range(0, 8) : 0;
		if ($urandom_range(0, 3) == 0) idle_cycles = 0;
		repeat (idle_cycles) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		item.req_type <= kind;
		item.ch <= c;
		item.last_char <= last;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		board.note_request('{req_type: kind, ch: c, last_char: last});
		requests_sent++;
	endtask

	task automatic send_name(logic kind, string s, bit gaps);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(kind, s[i], i == s.len() - 1, gaps);
	endtask

	// random name built from pool labels with dots, sometimes with a noisy prefix
	function automatic string random_name();
		string s;
		int parts;
		int i;
		parts = $urandom_range(1, 3);
		s = label_pool[$urandom_range(0, 7)];
		for (i = 1; i < parts; i++) s = {label_pool[$urandom_range(0, 7)], ".", s};
		// prefix without a dot so that plain suffixes must not match
		if ($urandom_range(0, 5) == 0) s = {"z", s};
		return s;
	endfunction

	task automatic send_random_bytes(int n, bit gaps);
		int i;
		logic kind;
		for (i = 0; i < n; i++) begin
			// mixed tags inside a name; only the last one counts
			kind = 1'($urandom_range(0, 1));
			send_char(kind, 8'($urandom_range(0, 255)), i == n - 1, gaps);
		end
	endtask

	task automatic send_long_name(logic kind, int n);
		int i;
		for (i = 0; i < n; i++) send_char(kind, 8'h61, i == n - 1, 0);
	endtask

	// receiver: random stalls, plus one long hold-off asked by the sender
	initial begin
		int stall_cycles;
		result_stall = 1;
		forever begin
			@(posedge clk);
			if (hold_results) begin
				result_stall <= 1;
				repeat (300) @(posedge clk);
				hold_results = 0;
			end
			stall_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
			if (stall_cycles > 0) begin
				result_stall <= 1;
				repeat (stall_cycles) @(posedge clk);
			end
			result_stall <= 0;
		end
	end

	// result monitor samples at the edge, after the inputs settled
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) board.check_result(result);
	end

	initial begin
		board = new();
		board.clear();
		item_valid = 0;
		item = '0;
		requests_sent = 0;
		hold_results = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: query on empty table, exact and dotted suffix hits and misses
		send_name(REQ_QUERY, "ads.com", 0);
		send_name(REQ_ADD, "evil.com", 0);
		send_name(REQ_QUERY, "evil.com", 0);
		send_name(REQ_QUERY, "a.evil.com", 0);
		send_name(REQ_QUERY, "aevil.com", 0);
		send_name(REQ_QUERY, "vil.com", 0);
		// extreme characters, single character name
		send_char(REQ_ADD, 8'hFF, 1, 0);
		send_char(REQ_QUERY, 8'hFF, 1, 0);
		send_char(REQ_QUERY, 8'h00, 1, 0);
		// exactly at the name limit
		send_long_name(REQ_QUERY, 256);
		send_random_bytes(6, 0);

		// random: mostly well formed names
		while (requests_sent < 400) begin
			case ($urandom_range(0, 9))
				0, 1, 2: send_name(REQ_ADD, random_name(), 1);
				3: send_random_bytes($urandom_range(1, 6), 1);
				default: send_name(REQ_QUERY, random_name(), 1);
			endcase
		end
		// long receiver hold-off while names keep streaming in
		hold_results = 1;
		repeat (4) send_name(REQ_QUERY, random_name(), 0);
		// fill the table with short entries, go past full and query the result
		while (board.entry_total < 64) send_char(REQ_ADD, 8'h78, 1, 0);
		repeat (3) send_name(REQ_ADD, random_name(), 1);
		repeat (10) send_name(REQ_QUERY, random_name(), 1);
		// one past the name limit on a full table: too long wins
		send_long_name(REQ_ADD, 257);
		item_valid <= 0;

		while (board.verdict_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d characters, checked %0d results", requests_sent, board.results_seen);
		$display("blocked %0d, table full %0d, too long %0d", board.blocked_seen,
			board.full_seen, board.long_seen);
		if (board.errors == 0 && board.verdict_queue.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
